// File: design/tbdl_pkg.sv
// shared types, constants and helpers for the three-button debouncer
package tbdl_pkg;

  localparam int TIME_BITS   = 32;
  localparam int NOW_BITS    = 32;
  localparam int DEB_BITS    = 16;
  localparam int HOLD_BITS   = 20;
  localparam int CFG_BITS    = 20;
  localparam int CFG_IDX_BITS = 2;
  localparam int CMP_BITS    = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_TIME = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME     = CFG_IDX_BITS'(1);

  localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET = DEB_BITS'(50);
  localparam logic [HOLD_BITS-1:0] HOLD_RESET     = HOLD_BITS'(5000);

  typedef logic [TIME_BITS-1:0] time_t;

  // per-button result of one poll
  typedef struct packed {
    logic changed;
    logic level;
  } btn_status_t;

  // timestamp masked or zero-extended to the internal time width
  function automatic time_t to_time(input logic [NOW_BITS-1:0] now);
    logic [63:0] ext;
    ext = 64'(now);
    return ext[TIME_BITS-1:0];
  endfunction

endpackage

// File: design/tbdl_if.sv
// poll and result channel interfaces
interface tbdl_in_if;
  logic                          valid;
  logic                          ready;
  logic [tbdl_pkg::NOW_BITS-1:0] now_ms;
  logic                          relay_level;
  logic                          reset_level;
  logic                          factory_level;

  modport source (output valid, now_ms, relay_level, reset_level, factory_level,
                  input ready);
  modport sink (input valid, now_ms, relay_level, reset_level, factory_level,
                output ready);
endinterface

interface tbdl_out_if;
  logic valid;
  logic ready;
  logic relay_pressed;
  logic reset_pressed;
  logic long_press_fired;
  logic relay_stable;
  logic reset_stable;
  logic factory_stable;

  modport source (output valid, relay_pressed, reset_pressed, long_press_fired,
                  relay_stable, reset_stable, factory_stable, input ready);
  modport sink (input valid, relay_pressed, reset_pressed, long_press_fired,
                relay_stable, reset_stable, factory_stable, output ready);
endinterface

// File: design/three_button_debounce_long_press.sv
// top level of the three-button debouncer with long-press detection
//
//   channel  dir  handshake        word
//   in_ch    in   valid/ready      now_ms, relay/reset/factory raw levels
//   out_ch   out  valid/ready      press pulses, long press, debounced levels
//   cfg_*    in   cfg_we only      register index and write data
//
// one poll per cycle sustained while out_ch.ready holds; a poll goes through
// the input register, then the debounce/hold compare into the result register
// synchronous active-low reset sets all buttons released, timers cleared,
// registers to their defaults
// a stalled result holds the result register; the input register still
// takes a poll while empty, so in_ch.ready only drops with both stages full
module three_button_debounce_long_press (
  input  logic                              clk,
  input  logic                              rst_n,
  tbdl_in_if.sink                           in_ch,
  tbdl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [tbdl_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tbdl_pkg::CFG_BITS-1:0]     cfg_wdata
);

  // configuration registers
  logic [tbdl_pkg::DEB_BITS-1:0]  debounce_time_r;
  logic [tbdl_pkg::HOLD_BITS-1:0] hold_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r <= tbdl_pkg::DEBOUNCE_RESET;
      hold_time_r     <= tbdl_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tbdl_pkg::CFG_DEBOUNCE_TIME: debounce_time_r <= cfg_wdata[tbdl_pkg::DEB_BITS-1:0];
        tbdl_pkg::CFG_HOLD_TIME:     hold_time_r     <= cfg_wdata[tbdl_pkg::HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                          in_valid_r;
  logic [tbdl_pkg::NOW_BITS-1:0] now_r;
  logic                          relay_r, reset_r, factory_r;
  logic                          out_valid_r;
  logic                          advance;
  logic                          step;

  // result stage moves when empty or being taken
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      now_r     <= in_ch.now_ms;
      relay_r   <= in_ch.relay_level;
      reset_r   <= in_ch.reset_level;
      factory_r <= in_ch.factory_level;
    end
  end

  // per-button debounce, state commits only when the word moves on
  tbdl_pkg::time_t       now_t;
  tbdl_pkg::btn_status_t relay_st, reset_st, factory_st;
  logic                  fired;

  assign now_t = tbdl_pkg::to_time(now_r);

  tbdl_button u_relay (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (step),
    .now           (now_t),
    .raw           (relay_r),
    .debounce_time (debounce_time_r),
    .status        (relay_st)
  );

  tbdl_button u_reset (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (step),
    .now           (now_t),
    .raw           (reset_r),
    .debounce_time (debounce_time_r),
    .status        (reset_st)
  );

  tbdl_button u_factory (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (step),
    .now           (now_t),
    .raw           (factory_r),
    .debounce_time (debounce_time_r),
    .status        (factory_st)
  );

  // long press on the third button
  tbdl_long_press u_long (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (step),
    .now       (now_t),
    .hold_time (hold_time_r),
    .btn       (factory_st),
    .fired     (fired)
  );

  // result register
  logic relay_pressed_r, reset_pressed_r, fired_r;
  logic relay_stable_r, reset_stable_r, factory_stable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      // a press is a debounced fall
      relay_pressed_r  <= relay_st.changed && !relay_st.level;
      reset_pressed_r  <= reset_st.changed && !reset_st.level;
      fired_r          <= fired;
      relay_stable_r   <= relay_st.level;
      reset_stable_r   <= reset_st.level;
      factory_stable_r <= factory_st.level;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.relay_pressed    = relay_pressed_r;
  assign out_ch.reset_pressed    = reset_pressed_r;
  assign out_ch.long_press_fired = fired_r;
  assign out_ch.relay_stable     = relay_stable_r;
  assign out_ch.reset_stable     = reset_stable_r;
  assign out_ch.factory_stable   = factory_stable_r;

endmodule

// File: design/tbdl_button.sv
// debounce state and next-state logic for one button
module tbdl_button (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  tbdl_pkg::time_t               now,
  input  logic                          raw,
  input  logic [tbdl_pkg::DEB_BITS-1:0] debounce_time,
  output tbdl_pkg::btn_status_t         status
);

  logic            raw_prev_r, raw_prev_nxt;
  logic            deb_r, deb_nxt;
  tbdl_pkg::time_t change_r, change_nxt;
  tbdl_pkg::time_t elapsed;
  logic            settled;

  always_comb begin
    raw_prev_nxt = raw;
    change_nxt   = (raw != raw_prev_r) ? now : change_r;
    elapsed      = now - change_nxt;
    settled      = elapsed >= tbdl_pkg::TIME_BITS'(debounce_time);
    deb_nxt      = settled ? raw : deb_r;
  end

  assign status.changed = deb_nxt != deb_r;
  assign status.level   = deb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r <= 1'b1;
      deb_r      <= 1'b1;
      change_r   <= '0;
    end else if (en) begin
      raw_prev_r <= raw_prev_nxt;
      deb_r      <= deb_nxt;
      change_r   <= change_nxt;
    end
  end

endmodule

// File: design/tbdl_long_press.sv
// hold timer for the third button, fires once per press
module tbdl_long_press (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  tbdl_pkg::time_t                now,
  input  logic [tbdl_pkg::HOLD_BITS-1:0] hold_time,
  input  tbdl_pkg::btn_status_t          btn,
  output logic                           fired
);

  tbdl_pkg::time_t start_r, start_mid;
  logic            done_r, done_mid, done_nxt;
  tbdl_pkg::time_t held;

  always_comb begin
    start_mid = start_r;
    done_mid  = done_r;
    if (btn.changed) begin
      start_mid = btn.level ? '0 : now;
      done_mid  = 1'b0;
    end
    held  = now - start_mid;
    fired = !btn.level && !done_mid &&
            (tbdl_pkg::CMP_BITS'(held) >= tbdl_pkg::CMP_BITS'(hold_time));
    done_nxt = done_mid | fired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      done_r  <= 1'b0;
    end else if (en) begin
      start_r <= start_mid;
      done_r  <= done_nxt;
    end
  end

endmodule

// File: tb/sv/three_button_debounce_long_press_test.sv
// self-checking testbench for the three-button debouncer with long-press detection
`timescale 1ns / 100ps

module three_button_debounce_long_press_test;

  // index with no register behind it, writes to it must be ignored
  localparam logic [tbdl_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = tbdl_pkg::CFG_IDX_BITS'(3);

  // one result word, first member is the top bit
  typedef struct packed {
    logic relay_pressed;
    logic reset_pressed;
    logic long_press_fired;
    logic relay_stable;
    logic reset_stable;
    logic factory_stable;
  } poll_result_t;

  // mirrors the debouncer state and holds the results still owed by the block
  class button_scoreboard;
    logic [tbdl_pkg::DEB_BITS-1:0]  debounce_ms;
    logic [tbdl_pkg::HOLD_BITS-1:0] hold_ms;
    logic                           raw_prev [3];
    logic                           settled [3];
    tbdl_pkg::time_t                change_at [3];
    tbdl_pkg::time_t                press_start;
    logic                           long_done;
    poll_result_t                   pending_results [$];
    int unsigned                    errors;

    function new();
      debounce_ms = tbdl_pkg::DEBOUNCE_RESET;
      hold_ms     = tbdl_pkg::HOLD_RESET;
      for (int b = 0; b < 3; b++) begin
        raw_prev[b]  = 1'b1;
        settled[b]   = 1'b1;
        change_at[b] = '0;
      end
      press_start = '0;
      long_done   = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [tbdl_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [tbdl_pkg::CFG_BITS-1:0] data);
      case (idx)
        tbdl_pkg::CFG_DEBOUNCE_TIME: debounce_ms = data[tbdl_pkg::DEB_BITS-1:0];
        tbdl_pkg::CFG_HOLD_TIME:     hold_ms = data[tbdl_pkg::HOLD_BITS-1:0];
        default: ;
      endcase
    endfunction

    // returns 1 when the settled level of button b flips
    function logic settle(int b, logic raw, tbdl_pkg::time_t now);
      tbdl_pkg::time_t age;
      if (raw != raw_prev[b]) begin
        change_at[b] = now;
        raw_prev[b]  = raw;
      end
      age = now - change_at[b];
      if (age < tbdl_pkg::time_t'(debounce_ms)) return 1'b0;
      if (raw == settled[b]) return 1'b0;
      settled[b] = raw;
      return 1'b1;
    endfunction

    function void predict_poll(tbdl_pkg::time_t now, logic relay, logic rst_btn,
                               logic factory);
      poll_result_t    r;
      tbdl_pkg::time_t held;
      r = '0;
      r.relay_pressed = settle(0, relay, now) && !settled[0];
      r.reset_pressed = settle(1, rst_btn, now) && !settled[1];
      if (settle(2, factory, now)) begin
        press_start = settled[2] ? '0 : now;
        long_done   = 1'b0;
      end
      held = now - press_start;
      if (!settled[2] && !long_done && held >= tbdl_pkg::time_t'(hold_ms)) begin
        long_done          = 1'b1;
        r.long_press_fired = 1'b1;
      end
      r.relay_stable   = settled[0];
      r.reset_stable   = settled[1];
      r.factory_stable = settled[2];
      pending_results.push_back(r);
    endfunction

    function void check_result(poll_result_t got);
      poll_result_t want;
      string        field_names [6];
      field_names = '{"factory_stable", "reset_stable", "relay_stable",
                      "long_press_fired", "reset_pressed", "relay_pressed"};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %b", $time, got);
        return;
      end
      want = pending_results.pop_front();
      for (int i = 5; i >= 0; i--) begin
        if (want[i] !== got[i]) begin
          errors++;
          $display("%0t: %s expected %b actual %b", $time, field_names[i], want[i], got[i]);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [tbdl_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [tbdl_pkg::CFG_BITS-1:0]     cfg_wdata;

  tbdl_in_if  in_ch ();
  tbdl_out_if out_ch ();

  three_button_debounce_long_press dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  button_scoreboard sb = new();

  // idle odds in percent per cycle, changed between phases
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // raised by the stimulus to ask the receiver for one long hold-off
  bit          stall_req;

  // random walk of time and raw levels
  tbdl_pkg::time_t cur_time;
  logic            lv_relay;
  logic            lv_reset;
  logic            lv_factory;
  int              burst_left;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAIL three_button_debounce_long_press");
    $finish;
  end

  // offer one poll word, wait until taken, then record what it should produce
  task automatic send_poll(tbdl_pkg::time_t now, logic relay, logic rst_btn, logic factory);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.now_ms        <= now;
    in_ch.relay_level   <= relay;
    in_ch.reset_level   <= rst_btn;
    in_ch.factory_level <= factory;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.predict_poll(now, relay, rst_btn, factory);
  endtask

  // stop offering and wait for every owed result word
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // both registers, then a write to an unused index that must change nothing
  task automatic program_regs(logic [tbdl_pkg::DEB_BITS-1:0] deb,
                              logic [tbdl_pkg::HOLD_BITS-1:0] hold);
    logic [tbdl_pkg::CFG_BITS-1:0] junk;
    junk = tbdl_pkg::CFG_BITS'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= tbdl_pkg::CFG_DEBOUNCE_TIME;
    cfg_wdata <= tbdl_pkg::CFG_BITS'(deb);
    @(posedge clk);
    sb.write_reg(tbdl_pkg::CFG_DEBOUNCE_TIME, tbdl_pkg::CFG_BITS'(deb));
    cfg_index <= tbdl_pkg::CFG_HOLD_TIME;
    cfg_wdata <= tbdl_pkg::CFG_BITS'(hold);
    @(posedge clk);
    sb.write_reg(tbdl_pkg::CFG_HOLD_TIME, tbdl_pkg::CFG_BITS'(hold));
    cfg_index <= CFG_UNUSED_IDX;
    cfg_wdata <= junk;
    @(posedge clk);
    sb.write_reg(CFG_UNUSED_IDX, junk);
    cfg_we <= 1'b0;
  endtask

  // mostly steady buttons with short bounce bursts, time steps scaled to the
  // current settings so that debounce and hold both get crossed, plus a few
  // fully random words
  task automatic random_polls(int n);
    int unsigned span;
    int unsigned flip_pct;
    span = 32'(sb.debounce_ms) / 2 + 32'(sb.hold_ms) / 16 + 4;
    for (int k = 0; k < n; k++) begin
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(99) < 3) begin
        burst_left = $urandom_range(6, 2);
      end
      flip_pct = (burst_left > 0) ? 40 : 2;
      if ($urandom_range(99) < flip_pct) lv_relay = !lv_relay;
      if ($urandom_range(99) < flip_pct) lv_reset = !lv_reset;
      if ($urandom_range(99) < flip_pct) lv_factory = !lv_factory;
      if ($urandom_range(99) < 4) begin
        send_poll(tbdl_pkg::time_t'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        cur_time = cur_time + tbdl_pkg::time_t'($urandom_range(span));
        send_poll(cur_time, lv_relay, lv_reset, lv_factory);
      end
    end
  endtask

  // result side: check every taken word, then pick ready for the next cycle
  initial begin
    int unsigned stall_left;
    poll_result_t got;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.relay_pressed    = out_ch.relay_pressed;
        got.reset_pressed    = out_ch.reset_pressed;
        got.long_press_fired = out_ch.long_press_fired;
        got.relay_stable     = out_ch.relay_stable;
        got.reset_stable     = out_ch.reset_stable;
        got.factory_stable   = out_ch.factory_stable;
        sb.check_result(got);
      end
      // long hold-off so both stages fill and the input backs up
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.now_ms        = '0;
    in_ch.relay_level   = 1'b1;
    in_ch.reset_level   = 1'b1;
    in_ch.factory_level = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = tbdl_pkg::CFG_DEBOUNCE_TIME;
    cfg_wdata           = '0;
    send_idle_pct       = 37;
    recv_idle_pct       = 54;
    stall_req           = 1'b0;
    burst_left          = 0;
    lv_relay            = 1'b1;
    lv_reset            = 1'b1;
    lv_factory          = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 50 ms debounce, 5000 ms hold
    send_poll(32'd0, 1'b1, 1'b1, 1'b1);
    send_poll(32'd10, 1'b0, 1'b1, 1'b1);      // relay starts falling
    send_poll(32'd59, 1'b0, 1'b1, 1'b1);      // one ms short
    send_poll(32'd60, 1'b0, 1'b1, 1'b1);      // relay press pulse
    send_poll(32'd70, 1'b0, 1'b0, 1'b0);
    send_poll(32'd90, 1'b0, 1'b1, 1'b0);      // reset bounces back
    send_poll(32'd120, 1'b0, 1'b1, 1'b0);     // factory settles pressed
    send_poll(32'd5119, 1'b0, 1'b1, 1'b0);    // just before the hold time
    send_poll(32'd5120, 1'b0, 1'b1, 1'b0);    // long press fires
    send_poll(32'd9000, 1'b1, 1'b1, 1'b0);    // still held, no second fire
    send_poll(32'd9050, 1'b1, 1'b1, 1'b1);    // relay settles released
    send_poll(32'd9100, 1'b1, 1'b1, 1'b1);    // factory release rearms
    wait_drained();

    // zero debounce and zero hold
    program_regs(tbdl_pkg::DEB_BITS'(0), tbdl_pkg::HOLD_BITS'(0));
    send_poll(32'd200, 1'b1, 1'b1, 1'b1);
    send_poll(32'd201, 1'b1, 1'b0, 1'b0);     // press and fire in one poll
    send_poll(32'd202, 1'b0, 1'b0, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    wait_drained();

    // largest settings across the timestamp wrap
    program_regs(tbdl_pkg::DEB_BITS'(16'hFFFF), tbdl_pkg::HOLD_BITS'(20'hF_FFFF));
    send_poll(32'hFFFF_FF00, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_FEFE, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_FEFF, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0010_FEFD, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0010_FEFE, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0010_FEFF, 1'b0, 1'b0, 1'b0);
    wait_drained();

    // typical settings, one long receiver hold-off in the middle
    program_regs(tbdl_pkg::DEB_BITS'(20), tbdl_pkg::HOLD_BITS'(300));
    cur_time = 32'hFFFF_FFFF - tbdl_pkg::time_t'($urandom_range(3000));
    random_polls(200);
    stall_req = 1'b1;
    random_polls(250);
    wait_drained();

    // largest settings, idle odds swapped
    send_idle_pct = 54;
    recv_idle_pct = 37;
    program_regs(tbdl_pkg::DEB_BITS'(16'hFFFF), tbdl_pkg::HOLD_BITS'(20'hF_FFFF));
    cur_time = 32'hFFFF_FFFF - tbdl_pkg::time_t'($urandom_range(5000000));
    random_polls(450);
    wait_drained();

    // smallest settings, no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(tbdl_pkg::DEB_BITS'(0), tbdl_pkg::HOLD_BITS'(0));
    cur_time = tbdl_pkg::time_t'($urandom);
    random_polls(400);
    wait_drained();

    // random middle settings
    program_regs(tbdl_pkg::DEB_BITS'($urandom_range(3000)),
                 tbdl_pkg::HOLD_BITS'($urandom_range(60000)));
    cur_time = tbdl_pkg::time_t'($urandom);
    random_polls(400);
    wait_drained();

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS three_button_debounce_long_press");
    end else begin
      $display("FAIL three_button_debounce_long_press");
    end
    $finish;
  end

endmodule
